// ----- hw/rtl/icr_pkg.sv -----
`timescale 1ns / 1ps

package icr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 7;
    localparam int unsigned ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_ISR = 7'd0;
    localparam logic [ADDR_W-1:0] ADDR_IPR = 7'd1;
    localparam logic [ADDR_W-1:0] ADDR_IER = 7'd2;
    localparam logic [ADDR_W-1:0] ADDR_IAR = 7'd3;
    localparam logic [ADDR_W-1:0] ADDR_SIE = 7'd4;
    localparam logic [ADDR_W-1:0] ADDR_CIE = 7'd5;
    localparam logic [ADDR_W-1:0] ADDR_IVR = 7'd6;
    localparam logic [ADDR_W-1:0] ADDR_MER = 7'd7;
    localparam logic [ADDR_W-1:0] ADDR_IMR = 7'd8;
    localparam logic [ADDR_W-1:0] ADDR_IVAR = 7'd64;

    // IVAR window starts at word 64: bit 6 of the address selects it
    localparam int unsigned IVAR_SEL_BIT = 6;

    localparam int unsigned MER_ME_BIT  = 0;
    localparam int unsigned MER_HIE_BIT = 1;

    localparam logic [DATA_W-1:0] NONE_PENDING = 32'hFFFF_FFFF;

endpackage

// ----- hw/rtl/interrupt_controller_regs_top.sv -----
`timescale 1ns / 1ps
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+-------------------------------------------
// input    | i_in_valid   | o_in_ready   | i_action, i_source_lines, i_word_address,
//          |              |              | i_write_data
// output   | o_out_valid  | i_out_ready  | o_read_data, o_irq_request, o_fast_vector,
//          |              |              | o_fast_valid
// One item per cycle sustained while the output is not stalled.
// An item sits in the input register, then updates the register file and the
// result register in one step (priority encode plus IVAR read is the long path).
// Synchronous active-low reset clears control, status and IVAR valid bits.
// A stalled output holds its result; the input register still fills behind it.

module interrupt_controller_regs_top #(
    parameter int unsigned NUM_SOURCES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [icr_pkg::ACT_W-1:0]         i_action,
    input  logic [icr_pkg::DATA_W-1:0]        i_source_lines,
    input  logic [icr_pkg::ADDR_W-1:0]        i_word_address,
    input  logic [icr_pkg::DATA_W-1:0]        i_write_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [icr_pkg::DATA_W-1:0]        o_read_data,
    output logic                              o_irq_request,
    output logic [icr_pkg::DATA_W-1:0]        o_fast_vector,
    output logic                              o_fast_valid
);

    localparam int unsigned IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int unsigned OFF_W = icr_pkg::IVAR_SEL_BIT;

    // input register
    logic                          r_in_valid;
    logic [icr_pkg::ACT_W-1:0]     r_action;
    logic [NUM_SOURCES-1:0]        r_lines;
    logic [icr_pkg::ADDR_W-1:0]    r_addr;
    logic [icr_pkg::DATA_W-1:0]    r_wdata;

    // register file
    logic [NUM_SOURCES-1:0]        r_isr, n_isr;
    logic [NUM_SOURCES-1:0]        r_ier, n_ier;
    logic [NUM_SOURCES-1:0]        r_imr, n_imr;
    logic                          r_me, n_me;
    logic                          r_hie, n_hie;
    logic [icr_pkg::DATA_W-1:0]    r_ivar_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0]        r_ivar_vld;

    // result register
    logic                          r_out_valid;
    logic [icr_pkg::DATA_W-1:0]    r_read_data;
    logic                          r_irq;
    logic [icr_pkg::DATA_W-1:0]    r_fast_vector;
    logic                          r_fast_valid;

    logic                          w_adv;
    logic [OFF_W-1:0]              w_off;
    logic                          w_ivar_hit;
    logic [IDX_W-1:0]              w_idx;
    logic                          w_rd_ivar;
    logic                          w_wr_ivar;
    logic [NUM_SOURCES-1:0]        w_wd;
    logic [NUM_SOURCES-1:0]        w_pend;
    logic                          w_any;
    logic [IDX_W-1:0]              w_top;
    logic                          w_req;
    logic                          w_fast;
    logic [icr_pkg::DATA_W-1:0]    w_rd_reg;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_off      = r_addr[OFF_W-1:0];
    assign w_ivar_hit = r_addr[icr_pkg::IVAR_SEL_BIT] && (w_off < OFF_W'(NUM_SOURCES));
    assign w_idx      = w_off[IDX_W-1:0];
    assign w_rd_ivar  = (r_action == icr_pkg::ACT_READ) && w_ivar_hit;
    assign w_wr_ivar  = (r_action == icr_pkg::ACT_WRITE) && w_ivar_hit;
    assign w_wd       = r_wdata[NUM_SOURCES-1:0];

    always_comb begin
        n_isr = r_isr;
        n_ier = r_ier;
        n_imr = r_imr;
        n_me  = r_me;
        n_hie = r_hie;
        unique case (r_action)
            icr_pkg::ACT_TICK: begin
                if (r_hie) begin
                    n_isr = r_isr | r_lines;
                end
            end
            icr_pkg::ACT_WRITE: begin
                unique case (r_addr)
                    icr_pkg::ADDR_ISR: begin
                        if (!r_hie) begin
                            n_isr = w_wd;
                        end
                    end
                    icr_pkg::ADDR_IER: n_ier = w_wd;
                    icr_pkg::ADDR_IAR: n_isr = r_isr & ~w_wd;
                    icr_pkg::ADDR_SIE: n_ier = r_ier | w_wd;
                    icr_pkg::ADDR_CIE: n_ier = r_ier & ~w_wd;
                    icr_pkg::ADDR_MER: begin
                        n_me  = r_wdata[icr_pkg::MER_ME_BIT];
                        n_hie = r_hie | r_wdata[icr_pkg::MER_HIE_BIT];
                    end
                    icr_pkg::ADDR_IMR: n_imr = w_wd;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // lowest-numbered pending source after this item
    assign w_pend = n_isr & n_ier;
    assign w_any  = |w_pend;

    always_comb begin
        w_top = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (w_pend[i]) begin
                w_top = IDX_W'(i);
            end
        end
    end

    assign w_req  = n_me && w_any;
    assign w_fast = w_req && n_imr[w_top];

    always_comb begin
        w_rd_reg = '0;
        if (r_action == icr_pkg::ACT_READ) begin
            unique case (r_addr)
                icr_pkg::ADDR_ISR: w_rd_reg = icr_pkg::DATA_W'(r_isr);
                icr_pkg::ADDR_IPR: w_rd_reg = icr_pkg::DATA_W'(r_isr & r_ier);
                icr_pkg::ADDR_IER: w_rd_reg = icr_pkg::DATA_W'(r_ier);
                icr_pkg::ADDR_IVR: begin
                    w_rd_reg = w_any ? icr_pkg::DATA_W'(w_top) : icr_pkg::NONE_PENDING;
                end
                icr_pkg::ADDR_MER: w_rd_reg = icr_pkg::DATA_W'({r_hie, r_me});
                icr_pkg::ADDR_IMR: w_rd_reg = icr_pkg::DATA_W'(r_imr);
                default: w_rd_reg = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_isr       <= '0;
            r_ier       <= '0;
            r_imr       <= '0;
            r_me        <= 1'b0;
            r_hie       <= 1'b0;
            r_ivar_vld  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_isr <= n_isr;
                r_ier <= n_ier;
                r_imr <= n_imr;
                r_me  <= n_me;
                r_hie <= n_hie;
                if (w_wr_ivar) begin
                    r_ivar_vld[w_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_lines  <= i_source_lines[NUM_SOURCES-1:0];
            r_addr   <= i_word_address;
            r_wdata  <= i_write_data;
        end
    end

    // IVAR memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_wr_ivar) begin
                r_ivar_mem[w_idx] <= r_wdata;
            end
            if (w_rd_ivar) begin
                r_read_data <= r_ivar_vld[w_idx] ? r_ivar_mem[w_idx] : '0;
            end else begin
                r_read_data <= w_rd_reg;
            end
            if (!w_fast) begin
                r_fast_vector <= '0;
            end else if (w_wr_ivar && (w_idx == w_top)) begin
                r_fast_vector <= r_wdata;
            end else begin
                r_fast_vector <= r_ivar_vld[w_top] ? r_ivar_mem[w_top] : '0;
            end
            r_irq        <= w_req;
            r_fast_valid <= w_fast;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_irq_request = r_irq;
    assign o_fast_vector = r_fast_vector;
    assign o_fast_valid  = r_fast_valid;

endmodule

// ----- hw/rtl/icr_checker.sv -----
`timescale 1ns / 1ps

module icr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_irq_request,
    input logic [icr_pkg::DATA_W-1:0] o_fast_vector,
    input logic                       o_fast_valid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_fast_needs_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fast_valid |-> o_irq_request)
        else $error("fast vector without interrupt request");

    a_vector_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_fast_valid |-> o_fast_vector == '0)
        else $error("fast vector nonzero while not fast");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind interrupt_controller_regs_top icr_checker u_icr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_irq_request (o_irq_request),
    .o_fast_vector (o_fast_vector),
    .o_fast_valid  (o_fast_valid)
);
